>>> src/wgl_pkg.sv
// Shared types and constants for the waypoint guidance pipeline.
// No dependencies; imported by waypoint_guidance_law.
`timescale 1ns / 1ps

package wgl_pkg;

    // Default number of CORDIC micro-rotations
    localparam int CORDIC_STAGES_DEF = 16;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // CORDIC datapath width: 33-bit difference, 8 guard bits, gain growth headroom
    localparam int CW = 44;
    // Distance width in Q16.16, with headroom above the 32-bit radius
    localparam int DW = 37;
    // High part of the magnitude, from bit 32 up
    localparam int HW = CW - 32;

    // Inverse CORDIC gain, 0.32 fraction
    localparam logic [31:0] INV_CORDIC_GAIN = 32'h9B74_EDA8;

    // Rounding offset added to the angle before taking its top 16 bits
    localparam logic [31:0] HEADING_ROUND = 32'h0000_8000;
    // Rotation by pi for the left half plane
    localparam logic [31:0] ANGLE_PI = 32'h8000_0000;

    // Reset values of the configuration registers
    localparam logic [15:0] GAIN_RESET   = 16'd256;
    localparam logic [31:0] RADIUS_RESET = 32'd65536;

    // Arctangent of 2^-i, 2^32 = 2*pi
    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X       = 3'd0,
        REG_TARGET_Y       = 3'd1,
        REG_TARGET_Z       = 3'd2,
        REG_LOOP_GAIN      = 3'd3,
        REG_ARRIVAL_RADIUS = 3'd4,
        REG_HALT_ON_ARRIVAL = 3'd5
    } cfg_reg_t;

    // Fields that ride alongside the datapath after the CORDIC
    typedef struct packed {
        logic        [15:0] heading;
        logic signed [31:0] climb;
    } side_t;

endpackage

>>> src/waypoint_guidance_law.sv
// Pipeline: CORDIC_STAGES + 6 register stages.
// Throughput: one word per cycle while out_stall is low; every stage is
// registered and the stall ripples back per stage, so bubbles are squeezed out.
// Reset: valid bits clear, configuration returns to target 0,0,0,
// gain 1.0, arrival radius 1.0 m, halt on arrival off.
// Depends on wgl_pkg for constants, the arctangent table and types.
`timescale 1ns / 1ps

module waypoint_guidance_law #(
    parameter int CORDIC_STAGES = wgl_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [wgl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wgl_pkg::CFG_DATA_W-1:0]      cfg_data,
    // position input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  pos_x,
    input  logic signed [31:0]                  pos_y,
    input  logic signed [31:0]                  pos_z,
    // command output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [31:0]                         speed_command,
    output logic signed [15:0]                  heading_command,
    output logic signed [31:0]                  climb_command,
    output logic                                reached,
    output logic                                stop_request
);
    import wgl_pkg::*;

    localparam int N = CORDIC_STAGES;
    // diff, prerotate, N micro-rotations, descale low, descale high, gain, output
    localparam int L = N + 6;
    localparam int S_M1  = N + 2;
    localparam int S_M2  = N + 3;
    localparam int S_M3  = N + 4;
    localparam int S_OUT = N + 5;

    // Configuration registers
    logic signed [31:0] target_x_reg, target_y_reg, target_z_reg;
    logic        [15:0] loop_gain_reg;
    logic        [31:0] arrival_radius_reg;
    logic               halt_on_arrival_reg;

    // Write configuration; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg        <= '0;
            target_y_reg        <= '0;
            target_z_reg        <= '0;
            loop_gain_reg       <= GAIN_RESET;
            arrival_radius_reg  <= RADIUS_RESET;
            halt_on_arrival_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET_X:        target_x_reg        <= cfg_data;
                REG_TARGET_Y:        target_y_reg        <= cfg_data;
                REG_TARGET_Z:        target_z_reg        <= cfg_data;
                REG_LOOP_GAIN:       loop_gain_reg       <= cfg_data[15:0];
                REG_ARRIVAL_RADIUS:  arrival_radius_reg  <= cfg_data;
                REG_HALT_ON_ARRIVAL: halt_on_arrival_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Valid bits and per-stage enables
    logic [L-1:0] v_reg;
    logic [L-1:0] en;

    assign en[L-1] = !v_reg[L-1] || !out_stall;
    genvar k;
    generate
        for (k = 0; k < L - 1; k++)
        begin : g_en
            assign en[k] = !v_reg[k] || en[k+1];
        end
    endgenerate

    assign in_stall  = !en[0];
    assign out_valid = v_reg[L-1];

    // Advance valid bits wherever a stage is free to load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < L; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Stage 0: differences target minus position, exact in 33 bits
    logic signed [32:0] dx_reg, dy_reg, dz_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg <= 33'(target_x_reg) - 33'(pos_x);
            dy_reg <= 33'(target_y_reg) - 33'(pos_y);
            dz_reg <= 33'(target_z_reg) - 33'(pos_z);
        end
    end

    // CORDIC state per stage
    logic signed [CW-1:0] x_reg    [0:N];
    logic signed [CW-1:0] y_reg    [0:N];
    logic        [31:0]   ang_reg  [0:N];
    logic                 zero_reg [0:N];
    logic signed [31:0]   climb_reg [0:N];

    // Stage 1: fold the left half plane, add guard bits, form the climb
    logic signed [CW-1:0] dx_ext, dy_ext;
    logic signed [49:0]   climb_prod;
    logic signed [41:0]   climb_shift;
    logic signed [31:0]   climb_sat;

    always_comb
    begin
        dx_ext      = CW'(dx_reg);
        dy_ext      = CW'(dy_reg);
        climb_prod  = 50'(dz_reg) * 50'($signed({1'b0, loop_gain_reg}));
        climb_shift = 42'(climb_prod >>> 8);
        if (climb_shift > 42'sd2147483647)
        begin
            climb_sat = 32'sh7FFF_FFFF;
        end
        else if (climb_shift < -42'sd2147483648)
        begin
            climb_sat = 32'sh8000_0000;
        end
        else
        begin
            climb_sat = climb_shift[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            if (dx_reg < 0)
            begin
                x_reg[0]   <= (-dx_ext) <<< 8;
                y_reg[0]   <= (-dy_ext) <<< 8;
                ang_reg[0] <= ANGLE_PI;
            end
            else
            begin
                x_reg[0]   <= dx_ext <<< 8;
                y_reg[0]   <= dy_ext <<< 8;
                ang_reg[0] <= '0;
            end
            zero_reg[0]  <= (dx_reg == 0) && (dy_reg == 0);
            climb_reg[0] <= climb_sat;
        end
        // Micro-rotations, one per stage, driving y toward zero
        for (int s = 0; s < N; s++)
        begin
            if (en[s+2])
            begin
                if (!y_reg[s][CW-1])
                begin
                    x_reg[s+1]   <= x_reg[s] + (y_reg[s] >>> s);
                    y_reg[s+1]   <= y_reg[s] - (x_reg[s] >>> s);
                    ang_reg[s+1] <= ang_reg[s] + ATAN_TABLE[s];
                end
                else
                begin
                    x_reg[s+1]   <= x_reg[s] - (y_reg[s] >>> s);
                    y_reg[s+1]   <= y_reg[s] + (x_reg[s] >>> s);
                    ang_reg[s+1] <= ang_reg[s] - ATAN_TABLE[s];
                end
                zero_reg[s+1]  <= zero_reg[s];
                climb_reg[s+1] <= climb_reg[s];
            end
        end
    end

    // M1: clamp magnitude, scale its low word, round the heading
    logic [CW-1:0] mag;
    logic [31:0]   ang_round;
    logic [63:0]   lo_prod_reg;
    logic [HW-1:0] hi_reg;
    side_t         side_m1_reg, side_m2_reg, side_m3_reg;

    always_comb
    begin
        mag       = x_reg[N][CW-1] ? '0 : x_reg[N];
        ang_round = ang_reg[N] + HEADING_ROUND;
    end

    always_ff @(posedge clk)
    begin
        if (en[S_M1])
        begin
            lo_prod_reg         <= 64'(mag[31:0]) * 64'(INV_CORDIC_GAIN);
            hi_reg              <= mag[CW-1:32];
            side_m1_reg.heading <= zero_reg[N] ? 16'd0 : ang_round[31:16];
            side_m1_reg.climb   <= climb_reg[N];
        end
    end

    // M2: scale the high part and round to Q16.16
    logic [CW:0]   dist_sum;
    logic [DW-1:0] dist_reg;

    assign dist_sum = (CW+1)'(hi_reg) * (CW+1)'(INV_CORDIC_GAIN)
                    + (CW+1)'(lo_prod_reg[63:32]) + (CW+1)'(128);

    always_ff @(posedge clk)
    begin
        if (en[S_M2])
        begin
            dist_reg    <= dist_sum[CW:8];
            side_m2_reg <= side_m1_reg;
        end
    end

    // M3: apply the gain and test for arrival
    logic [DW+15:0] speed_prod_reg;
    logic           reached_m3_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_M3])
        begin
            speed_prod_reg <= (DW+16)'(loop_gain_reg) * (DW+16)'(dist_reg);
            reached_m3_reg <= dist_reg < DW'(arrival_radius_reg);
            side_m3_reg    <= side_m2_reg;
        end
    end

    // Output register: saturate the speed
    logic [31:0]        speed_reg;
    logic signed [15:0] heading_reg;
    logic signed [31:0] climb_out_reg;
    logic               reached_reg;
    logic               stop_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            speed_reg     <= (|speed_prod_reg[DW+15:40]) ? 32'hFFFF_FFFF
                                                         : speed_prod_reg[39:8];
            heading_reg   <= side_m3_reg.heading;
            climb_out_reg <= side_m3_reg.climb;
            reached_reg   <= reached_m3_reg;
            stop_reg      <= reached_m3_reg && halt_on_arrival_reg;
        end
    end

    assign speed_command   = speed_reg;
    assign heading_command = heading_reg;
    assign climb_command   = climb_out_reg;
    assign reached         = reached_reg;
    assign stop_request    = stop_reg;

endmodule

>>> tb/tb_waypoint_guidance_law.sv
// Self-checking testbench for waypoint_guidance_law: drives position words,
// predicts each guidance command and compares it field by field.
// Depends on wgl_pkg and the waypoint_guidance_law RTL.
`timescale 1ns / 1ps

module tb_waypoint_guidance_law;

    import wgl_pkg::*;

    localparam int LATENCY         = CORDIC_STAGES_DEF + 6;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 229;
    localparam int HOLD_OFF_CYCLES = 300;

    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam longint CLIMB_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint CLIMB_MIN = -64'sh0000_0000_8000_0000;

    // Register indexes past the end of the map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_7 = 3'd7;

    typedef struct {
        logic        [31:0] speed;
        logic signed [15:0] heading;
        logic signed [31:0] climb;
        logic               reached;
        logic               stop;
    } guidance_cmd_t;

    // Mirror of the register file, command prediction and the expected-command queue
    class command_scoreboard;
        logic signed [31:0] tgt_x;
        logic signed [31:0] tgt_y;
        logic signed [31:0] tgt_z;
        logic        [15:0] gain;
        logic        [31:0] radius;
        logic               halt;
        guidance_cmd_t      expected_cmds[$];
        int unsigned        positions_in;
        int unsigned        commands_seen;
        int unsigned        mismatches;

        function new();
            tgt_x = '0;
            tgt_y = '0;
            tgt_z = '0;
            gain = GAIN_RESET;
            radius = RADIUS_RESET;
            halt = 1'b0;
            positions_in = 0;
            commands_seen = 0;
            mismatches = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET_X:        tgt_x = data;
                REG_TARGET_Y:        tgt_y = data;
                REG_TARGET_Z:        tgt_z = data;
                REG_LOOP_GAIN:       gain = data[15:0];
                REG_ARRIVAL_RADIUS:  radius = data;
                REG_HALT_ON_ARRIVAL: halt = data[0];
                default: ;
            endcase
        endfunction

        function guidance_cmd_t predict_command(input logic signed [31:0] px,
                                                input logic signed [31:0] py,
                                                input logic signed [31:0] pz);
            guidance_cmd_t c;
            longint dx, dy, dz, x, y, xs, ys, climb;
            longint unsigned ux, distance, prod_hi, prod_lo, speed;
            logic [31:0] angle, rounded;
            int i;
            dx = longint'(tgt_x) - longint'(px);
            dy = longint'(tgt_y) - longint'(py);
            dz = longint'(tgt_z) - longint'(pz);
            distance = 0;
            angle = '0;
            // zero difference leaves distance and heading at zero
            if (dx != 0 || dy != 0)
            begin
                x = dx;
                y = dy;
                // fold the left half plane over by pi
                if (x < 0)
                begin
                    x = -x;
                    y = -y;
                    angle = ANGLE_PI;
                end
                x = x * 256;
                y = y * 256;
                for (i = 0; i < CORDIC_STAGES_DEF && i < 32; i++)
                begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0)
                    begin
                        x = x + ys;
                        y = y - xs;
                        angle = angle + ATAN_TABLE[i];
                    end
                    else
                    begin
                        x = x - ys;
                        y = y + xs;
                        angle = angle - ATAN_TABLE[i];
                    end
                end
                // scale out the CORDIC gain in two halves, round to Q16.16
                ux = (x > 0) ? x : 0;
                prod_hi = (ux >> 32) * INV_CORDIC_GAIN;
                prod_lo = (ux & 64'hFFFF_FFFF) * INV_CORDIC_GAIN;
                distance = (prod_hi + (prod_lo >> 32) + 128) >> 8;
            end
            speed = (64'(gain) * distance) >> 8;
            if (speed > 64'hFFFF_FFFF)
                speed = 64'hFFFF_FFFF;
            climb = (dz * longint'(gain)) >>> 8;
            if (climb > CLIMB_MAX)
                climb = CLIMB_MAX;
            if (climb < CLIMB_MIN)
                climb = CLIMB_MIN;
            rounded = angle + HEADING_ROUND;
            c.speed = speed[31:0];
            c.heading = rounded[31:16];
            c.climb = climb[31:0];
            c.reached = distance < 64'(radius);
            c.stop = c.reached & halt;
            return c;
        endfunction

        function void note_position(input logic signed [31:0] px,
                                    input logic signed [31:0] py,
                                    input logic signed [31:0] pz);
            expected_cmds.push_back(predict_command(px, py, pz));
            positions_in++;
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_command(input guidance_cmd_t got);
            guidance_cmd_t want;
            commands_seen++;
            if (expected_cmds.size() == 0)
            begin
                $display("%0t: command with nothing expected, speed %h heading %h climb %h",
                         $time, got.speed, got.heading, got.climb);
                mismatches++;
                return;
            end
            want = expected_cmds.pop_front();
            check_field("speed_command", want.speed, got.speed);
            check_field("heading_command", want.heading, got.heading);
            check_field("climb_command", want.climb, got.climb);
            check_field("reached", want.reached, got.reached);
            check_field("stop_request", want.stop, got.stop);
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic out_valid;
    logic out_stall;
    logic [31:0] speed_command;
    logic signed [15:0] heading_command;
    logic signed [31:0] climb_command;
    logic reached;
    logic stop_request;

    command_scoreboard tracker;
    guidance_cmd_t observed;
    bit no_idle;
    bit flood;
    int hold_request;
    int unsigned cycle_count;
    int unsigned settings_used;

    waypoint_guidance_law uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .speed_command   (speed_command),
        .heading_command (heading_command),
        .climb_command   (climb_command),
        .reached         (reached),
        .stop_request    (stop_request)
    );

    always #2 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic int offset(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic signed [31:0] pick_extreme(input logic signed [31:0] center);
        case ($urandom_range(0, 5))
            0: return MIN32;
            1: return MAX32;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return center;
        endcase
    endfunction

    // Mix of near-waypoint, on-axis, extreme and fully random positions
    function automatic void pick_position(output logic signed [31:0] px,
                                          output logic signed [31:0] py,
                                          output logic signed [31:0] pz);
        int unsigned kind;
        int span;
        kind = $urandom_range(0, 99);
        span = 1 << $urandom_range(4, 24);
        px = $urandom;
        py = $urandom;
        pz = $urandom;
        if (kind < 40)
        begin
            px = tracker.tgt_x + offset(span);
            py = tracker.tgt_y + offset(span);
            pz = tracker.tgt_z + offset(span);
        end
        else if (kind < 52)
        begin
            if ($urandom_range(0, 1))
                px = tracker.tgt_x;
            else
                py = tracker.tgt_y;
        end
        else if (kind < 62)
        begin
            px = pick_extreme(tracker.tgt_x);
            py = pick_extreme(tracker.tgt_y);
            pz = pick_extreme(tracker.tgt_z);
        end
    endfunction

    function automatic logic [31:0] pick_target();
        case ($urandom_range(0, 4))
            0: return MIN32;
            1: return MAX32;
            2: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    // Write one register; the block must be idle
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        tracker.set_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic randomize_settings();
        logic [15:0] gain;
        logic [31:0] radius;
        case ($urandom_range(0, 4))
            0: gain = 16'd0;
            1: gain = 16'hFFFF;
            2: gain = GAIN_RESET;
            3: gain = 16'd1;
            default: gain = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: radius = 32'd0;
            1: radius = 32'hFFFF_FFFF;
            2: radius = $urandom_range(0, 1 << 20);
            3: radius = $urandom_range(0, 1 << 26);
            default: radius = $urandom;
        endcase
        program_reg(REG_TARGET_X, pick_target());
        program_reg(REG_TARGET_Y, pick_target());
        program_reg(REG_TARGET_Z, pick_target());
        // junk above bit 15 must be masked off
        program_reg(REG_LOOP_GAIN, {16'($urandom), gain});
        program_reg(REG_ARRIVAL_RADIUS, radius);
        program_reg(REG_HALT_ON_ARRIVAL, $urandom);
        if ($urandom_range(0, 2) == 0)
            program_reg($urandom_range(0, 1) ? IDX_SPARE_6 : IDX_SPARE_7, $urandom);
        settings_used++;
    endtask

    // Offer one position word and hold it until the block takes it
    task automatic send_position(input logic signed [31:0] px,
                                 input logic signed [31:0] py,
                                 input logic signed [31:0] pz);
        int unsigned gap;
        gap = (no_idle || flood) ? 0 : idle_len();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_position(px, py, pz);
    endtask

    // Drop valid and wait until every command is out
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Output stall: random runs, quiet stretches and the long hold-off
    initial
    begin : drive_out_stall
        int unsigned run_len;
        int hold_left;
        bit stalling;
        run_len = 0;
        hold_left = 0;
        stalling = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else
            begin
                if (run_len == 0)
                begin
                    stalling = ($urandom_range(0, 99) < 30);
                    run_len = stalling ? idle_len() + 1 : $urandom_range(1, 12);
                end
                out_stall <= stalling;
                run_len--;
            end
        end
    end

    // Check every accepted command word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed = '{speed_command, heading_command, climb_command,
                         reached, stop_request};
            tracker.check_command(observed);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_waypoint_guidance_law failed");
            $finish;
        end
    end

    initial
    begin : main_sequence
        logic signed [31:0] px, py, pz;
        int ph, k;
        tracker = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        no_idle = 1'b0;
        flood = 1'b0;
        hold_request = 0;
        cycle_count = 0;
        settings_used = 1;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: zero difference, the four axes, pi wrap, arrival edge
        send_position(32'sd0, 32'sd0, 32'sd0);
        send_position(32'sd65536, 32'sd0, 32'sd0);
        send_position(-32'sd65536, 32'sd0, 32'sd0);
        send_position(32'sd0, 32'sd65536, 32'sd0);
        send_position(32'sd0, -32'sd65536, 32'sd0);
        send_position(-32'sd65535, 32'sd0, 32'sd0);
        send_position(-32'sd65537, 32'sd0, 32'sd0);
        send_position(MIN32, MIN32, MIN32);
        send_position(MAX32, MAX32, MAX32);
        send_position(MIN32, MAX32, -32'sd1);
        send_position(MAX32, MIN32, 32'sd1);
        send_position(-32'sd1, -32'sd1, MAX32);
        settle();

        // Far corner target, full gain: speed and climb saturate, huge radius
        program_reg(REG_TARGET_X, MIN32);
        program_reg(REG_TARGET_Y, MAX32);
        program_reg(REG_TARGET_Z, MIN32);
        program_reg(REG_LOOP_GAIN, 32'h0000_FFFF);
        program_reg(REG_ARRIVAL_RADIUS, 32'hFFFF_FFFF);
        program_reg(REG_HALT_ON_ARRIVAL, 32'h0000_0001);
        settings_used++;
        send_position(MAX32, MIN32, MAX32);
        send_position(MIN32, MAX32, MIN32);
        send_position(MAX32, MAX32, MAX32);
        send_position(MIN32, MIN32, MIN32);
        settle();

        // Zero gain through masked data, zero radius; spare indexes ignored
        program_reg(REG_TARGET_X, $urandom);
        program_reg(REG_TARGET_Y, $urandom);
        program_reg(REG_LOOP_GAIN, 32'hABCD_0000);
        program_reg(REG_ARRIVAL_RADIUS, 32'd0);
        program_reg(REG_HALT_ON_ARRIVAL, 32'hFFFF_FFFE);
        program_reg(IDX_SPARE_6, 32'h7FFF_FFFF);
        program_reg(IDX_SPARE_7, 32'h0000_0001);
        settings_used++;
        send_position(32'sd0, 32'sd0, 32'sd0);
        send_position(tracker.tgt_x, tracker.tgt_y, tracker.tgt_z);
        send_position($urandom, $urandom, $urandom);
        send_position($urandom, tracker.tgt_y, $urandom);
        settle();

        // Random settings, each with a batch of random positions
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            randomize_settings();
            no_idle = (ph == 2);
            for (k = 0; k < WORDS_PER_PHASE; k++)
            begin
                // fill the pipeline against a long output hold-off
                if (ph == 4 && k == 60)
                begin
                    hold_request = HOLD_OFF_CYCLES;
                    flood = 1'b1;
                end
                if (ph == 4 && k == 120)
                    flood = 1'b0;
                pick_position(px, py, pz);
                send_position(px, py, pz);
            end
            settle();
        end
        no_idle = 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("Sent %0d position words under %0d register settings, with a %0d-cycle",
                 tracker.positions_in, settings_used, HOLD_OFF_CYCLES);
        $display("output hold-off; %0d commands compared, %0d mismatches.",
                 tracker.commands_seen, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb_waypoint_guidance_law passed");
        else
            $display("tb_waypoint_guidance_law failed");
        $finish;
    end

endmodule
